@@ rtl/ftcd_pkg.sv @@
// ----------------------------------------------------------------------------
// ftcd_pkg: shared types and constants for the tick-count to calendar converter
// Holds the fixed divisors, reciprocal multipliers and divider stage types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ftcd_pkg;

  // Pipeline depth from accepted word to result strobe
  localparam int DAY_STAGES = 13;
  localparam int SEC_STAGES = 9;
  localparam int LATENCY    = 26;

  // Divisors of the radix-4 long division stages
  localparam logic [41:0] TICKS_PER_DAY    = 42'd864000000000;
  localparam logic [41:0] TICKS_PER_DAY_X2 = TICKS_PER_DAY << 1;
  localparam logic [41:0] TICKS_PER_DAY_X3 = TICKS_PER_DAY + (TICKS_PER_DAY << 1);
  localparam logic [25:0] TICKS_PER_SEC    = 26'd10000000;
  localparam logic [25:0] TICKS_PER_SEC_X2 = TICKS_PER_SEC << 1;
  localparam logic [25:0] TICKS_PER_SEC_X3 = TICKS_PER_SEC + (TICKS_PER_SEC << 1);

  // Calendar and clock constants
  localparam logic [23:0] TICKS_PER_MS     = 24'd10000;
  localparam logic [24:0] EPOCH_SHIFT_DAYS = 25'd584694;
  localparam logic [24:0] DAYS_PER_ERA     = 25'd146097;
  localparam logic [17:0] LAST_DAY_OF_ERA  = 18'd146096;
  localparam logic [17:0] DAYS_PER_4Y      = 18'd1460;
  localparam logic [17:0] DAYS_PER_100Y    = 18'd36524;
  localparam logic [17:0] DAYS_PER_YEAR    = 18'd365;
  localparam logic [15:0] YEARS_PER_ERA    = 16'd400;
  localparam logic [10:0] DAYS_PER_5MONTH  = 11'd153;
  localparam logic [24:0] DAYS_PER_WEEK    = 25'd7;
  localparam logic [16:0] SECS_PER_MIN     = 17'd60;
  localparam logic [10:0] MIN_PER_HOUR     = 11'd60;

  // Reciprocals floor(2^SH / D); the estimate is low by at most one
  localparam int          ERA_SH      = 25;
  localparam logic [7:0]  ERA_RECIP   = 8'((2 ** 25) / 146097);
  localparam int          WK_SH       = 25;
  localparam logic [22:0] WK_RECIP    = 23'((2 ** 25) / 7);
  localparam int          DOE_SH      = 18;
  localparam logic [7:0]  Q4Y_RECIP   = 8'((2 ** 18) / 1460);
  localparam logic [2:0]  Q100Y_RECIP = 3'((2 ** 18) / 36524);
  localparam logic [9:0]  YEAR_RECIP  = 10'((2 ** 18) / 365);
  localparam int          MP_SH       = 11;
  localparam logic [3:0]  MP_RECIP    = 4'((2 ** 11) / 153);
  localparam int          MS_SH       = 24;
  localparam logic [10:0] MS_RECIP    = 11'((2 ** 24) / 10000);
  localparam int          MIN_SH      = 17;
  localparam logic [11:0] MIN_RECIP   = 12'((2 ** 17) / 60);

  // Partial remainder and shifting dividend/quotient of the day division
  typedef struct packed {
    logic [39:0] rem;
    logic [25:0] w;
  } day_div_t;

  // Partial remainder and shifting dividend/quotient of the second division
  typedef struct packed {
    logic [23:0] rem;
    logic [17:0] w;
  } sec_div_t;

  // First day of each month, counted from March, as (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start_day;
    case (mp)
      4'd0:    start_day = 9'd0;
      4'd1:    start_day = 9'd31;
      4'd2:    start_day = 9'd61;
      4'd3:    start_day = 9'd92;
      4'd4:    start_day = 9'd122;
      4'd5:    start_day = 9'd153;
      4'd6:    start_day = 9'd184;
      4'd7:    start_day = 9'd214;
      4'd8:    start_day = 9'd245;
      4'd9:    start_day = 9'd275;
      4'd10:   start_day = 9'd306;
      4'd11:   start_day = 9'd337;
      default: start_day = 9'd0;
    endcase
    return start_day;
  endfunction

endpackage

@@ rtl/filetime_to_civil_date.sv @@
// ----------------------------------------------------------------------------
// filetime_to_civil_date: 100 ns tick count to Gregorian date and time of day
// Splits the tick count into days, seconds and milliseconds by pipelined
// long division, then walks the day count through 400-year eras.
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   ---------------------------------------------
//  input     start / busy         tick_count
//  result    done (one cycle)     year, month, day_of_month, hour, minute,
//                                 second, millisecond, weekday
//
//  One word is taken every cycle while rst is low; each result appears at
//  done once its word has passed every stage. The depth is set by the radix-4
//  division of the tick count by one day (13 stages) and by one second (9
//  stages), plus the clock split and output stages. busy is high only while
//  rst is high. Reset clears the valid bits only. The receiver cannot stall,
//  so the pipeline never holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module filetime_to_civil_date (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] tick_count,
  output logic        done,
  output logic [15:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [9:0]  millisecond,
  output logic [2:0]  weekday
);

  // One radix-4 step of the division by ticks per day
  function automatic ftcd_pkg::day_div_t day_step(input ftcd_pkg::day_div_t s);
    logic [41:0]        t;
    logic [41:0]        sub;
    logic [1:0]         dig;
    ftcd_pkg::day_div_t o;
    t = {s.rem, s.w[25:24]};
    if (t >= ftcd_pkg::TICKS_PER_DAY_X3) begin
      dig = 2'd3;
      sub = ftcd_pkg::TICKS_PER_DAY_X3;
    end else if (t >= ftcd_pkg::TICKS_PER_DAY_X2) begin
      dig = 2'd2;
      sub = ftcd_pkg::TICKS_PER_DAY_X2;
    end else if (t >= ftcd_pkg::TICKS_PER_DAY) begin
      dig = 2'd1;
      sub = ftcd_pkg::TICKS_PER_DAY;
    end else begin
      dig = 2'd0;
      sub = '0;
    end
    o.rem = 40'(t - sub);
    o.w   = {s.w[23:0], dig};
    return o;
  endfunction

  // One radix-4 step of the division by ticks per second
  function automatic ftcd_pkg::sec_div_t sec_step(input ftcd_pkg::sec_div_t s);
    logic [25:0]        t;
    logic [25:0]        sub;
    logic [1:0]         dig;
    ftcd_pkg::sec_div_t o;
    t = {s.rem, s.w[17:16]};
    if (t >= ftcd_pkg::TICKS_PER_SEC_X3) begin
      dig = 2'd3;
      sub = ftcd_pkg::TICKS_PER_SEC_X3;
    end else if (t >= ftcd_pkg::TICKS_PER_SEC_X2) begin
      dig = 2'd2;
      sub = ftcd_pkg::TICKS_PER_SEC_X2;
    end else if (t >= ftcd_pkg::TICKS_PER_SEC) begin
      dig = 2'd1;
      sub = ftcd_pkg::TICKS_PER_SEC;
    end else begin
      dig = 2'd0;
      sub = '0;
    end
    o.rem = 24'(t - sub);
    o.w   = {s.w[15:0], dig};
    return o;
  endfunction

  logic [ftcd_pkg::LATENCY:1] vld;

  ftcd_pkg::day_div_t day_init;
  ftcd_pkg::day_div_t day_pipe [1:ftcd_pkg::DAY_STAGES];
  ftcd_pkg::sec_div_t sec_init;
  ftcd_pkg::sec_div_t sec_pipe [1:ftcd_pkg::SEC_STAGES];

  logic [24:0] days;
  logic [24:0] z_comb;
  logic [24:0] wx_comb;

  logic [24:0] k14_z;
  logic [32:0] k14_era_p;
  logic [24:0] k14_wx;
  logic [47:0] k14_wp;

  logic [7:0]  era_est;
  logic [24:0] era_rem;
  logic [22:0] wk_est;
  logic [24:0] wk_rem;
  logic [7:0]  k15_era;
  logic [17:0] k15_doe;
  logic [2:0]  wd_dly [15:ftcd_pkg::LATENCY];

  logic [7:0]  k16_era;
  logic [17:0] k16_doe;
  logic [25:0] k16_p4;
  logic [20:0] k16_p100;
  logic        k16_last;

  logic [7:0]  a_est;
  logic [17:0] a_rem;
  logic [2:0]  b_est;
  logic [17:0] b_rem;
  logic [7:0]  k17_era;
  logic [17:0] k17_doe;
  logic [7:0]  k17_a;
  logic [2:0]  k17_b;
  logic        k17_last;

  logic [7:0]  k18_era;
  logic [17:0] k18_doe;
  logic [17:0] k18_n;

  logic [7:0]  k19_era;
  logic [17:0] k19_doe;
  logic [17:0] k19_n;
  logic [27:0] k19_pn;

  logic [9:0]  y_est;
  logic [17:0] y_rem;
  logic [7:0]  k20_era;
  logic [17:0] k20_doe;
  logic [8:0]  k20_yoe;

  logic [1:0]  cent;
  logic [17:0] yday_start;
  logic [8:0]  k21_doy;
  logic [15:0] k21_yy;

  logic [10:0] t5_comb;
  logic [8:0]  k22_doy;
  logic [15:0] k22_yy;
  logic [10:0] k22_t5;
  logic [14:0] k22_pm;

  logic [3:0]  mp_est;
  logic [10:0] mp_rem;
  logic [8:0]  k23_doy;
  logic [15:0] k23_yy;
  logic [3:0]  k23_mp;

  logic [15:0] k24_year;
  logic [3:0]  k24_month;
  logic [4:0]  k24_day;
  logic [15:0] k25_year;
  logic [3:0]  k25_month;
  logic [4:0]  k25_day;
  logic [15:0] k26_year;
  logic [3:0]  k26_month;
  logic [4:0]  k26_day;

  logic [16:0] secs;
  logic [23:0] rem2;
  logic [34:0] k23_pms;
  logic [23:0] k23_rem2;
  logic [28:0] k23_pmin;
  logic [16:0] k23_secs;

  logic [10:0] ms_est;
  logic [23:0] ms_rem;
  logic [11:0] mt_est;
  logic [16:0] mt_rem;
  logic [9:0]  k24_ms;
  logic [10:0] k24_mt;
  logic [5:0]  k24_sec;

  logic [9:0]  k25_ms;
  logic [10:0] k25_mt;
  logic [5:0]  k25_sec;
  logic [22:0] k25_ph;

  logic [5:0]  h_est;
  logic [10:0] h_rem;
  logic [9:0]  k26_ms;
  logic [5:0]  k26_sec;
  logic [4:0]  k26_hour;
  logic [5:0]  k26_min;

  // Hold off input words only while in reset
  assign busy = rst;

  // Advance the valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[ftcd_pkg::LATENCY-1:1], start & ~busy};
    end
  end

  // Divide ticks by one day: quotient bits shift into w, two per stage
  always_comb begin
    day_init.rem = 40'(tick_count[63:26]);
    day_init.w   = tick_count[25:0];
  end

  always_ff @(posedge clk) begin
    day_pipe[1] <= day_step(day_init);
    for (int k = 2; k <= ftcd_pkg::DAY_STAGES; k++) begin
      day_pipe[k] <= day_step(day_pipe[k-1]);
    end
  end

  assign days = day_pipe[ftcd_pkg::DAY_STAGES].w[24:0];

  // Divide the ticks left within the day by one second
  always_comb begin
    sec_init.rem = 24'(day_pipe[ftcd_pkg::DAY_STAGES].rem[39:18]);
    sec_init.w   = day_pipe[ftcd_pkg::DAY_STAGES].rem[17:0];
  end

  always_ff @(posedge clk) begin
    sec_pipe[1] <= sec_step(sec_init);
    for (int k = 2; k <= ftcd_pkg::SEC_STAGES; k++) begin
      sec_pipe[k] <= sec_step(sec_pipe[k-1]);
    end
  end

  assign secs = sec_pipe[ftcd_pkg::SEC_STAGES].w[16:0];
  assign rem2 = sec_pipe[ftcd_pkg::SEC_STAGES].rem;

  // Shift the epoch and estimate the era; estimate the week count
  assign z_comb  = days + ftcd_pkg::EPOCH_SHIFT_DAYS;
  assign wx_comb = days + 25'd1;

  always_ff @(posedge clk) begin
    k14_z     <= z_comb;
    k14_era_p <= 33'(z_comb) * 33'(ftcd_pkg::ERA_RECIP);
    k14_wx    <= wx_comb;
    k14_wp    <= 48'(wx_comb) * 48'(ftcd_pkg::WK_RECIP);
  end

  // Correct the era and weekday estimates by one step
  assign era_est = k14_era_p[32:ftcd_pkg::ERA_SH];
  assign era_rem = k14_z - 25'(era_est) * ftcd_pkg::DAYS_PER_ERA;
  assign wk_est  = k14_wp[47:ftcd_pkg::WK_SH];
  assign wk_rem  = k14_wx - 25'(wk_est) * ftcd_pkg::DAYS_PER_WEEK;

  always_ff @(posedge clk) begin
    if (era_rem >= ftcd_pkg::DAYS_PER_ERA) begin
      k15_era <= era_est + 8'd1;
      k15_doe <= 18'(era_rem - ftcd_pkg::DAYS_PER_ERA);
    end else begin
      k15_era <= era_est;
      k15_doe <= 18'(era_rem);
    end
    if (wk_rem >= ftcd_pkg::DAYS_PER_WEEK) begin
      wd_dly[15] <= 3'(wk_rem - ftcd_pkg::DAYS_PER_WEEK);
    end else begin
      wd_dly[15] <= 3'(wk_rem);
    end
    for (int k = 16; k <= ftcd_pkg::LATENCY; k++) begin
      wd_dly[k] <= wd_dly[k-1];
    end
  end

  // Estimate the four-year and century counts within the era
  always_ff @(posedge clk) begin
    k16_era  <= k15_era;
    k16_doe  <= k15_doe;
    k16_p4   <= 26'(k15_doe) * 26'(ftcd_pkg::Q4Y_RECIP);
    k16_p100 <= 21'(k15_doe) * 21'(ftcd_pkg::Q100Y_RECIP);
    k16_last <= (k15_doe == ftcd_pkg::LAST_DAY_OF_ERA);
  end

  // Correct the four-year and century counts
  assign a_est = k16_p4[25:ftcd_pkg::DOE_SH];
  assign a_rem = k16_doe - 18'(a_est) * ftcd_pkg::DAYS_PER_4Y;
  assign b_est = k16_p100[20:ftcd_pkg::DOE_SH];
  assign b_rem = k16_doe - 18'(b_est) * ftcd_pkg::DAYS_PER_100Y;

  always_ff @(posedge clk) begin
    k17_era  <= k16_era;
    k17_doe  <= k16_doe;
    k17_last <= k16_last;
    k17_a    <= a_est + 8'(a_rem >= ftcd_pkg::DAYS_PER_4Y);
    k17_b    <= b_est + 3'(b_rem >= ftcd_pkg::DAYS_PER_100Y);
  end

  // Drop leap days to get a plain 365-day count
  always_ff @(posedge clk) begin
    k18_era <= k17_era;
    k18_doe <= k17_doe;
    k18_n   <= k17_doe - 18'(k17_a) + 18'(k17_b) - 18'(k17_last);
  end

  // Estimate the year of the era
  always_ff @(posedge clk) begin
    k19_era <= k18_era;
    k19_doe <= k18_doe;
    k19_n   <= k18_n;
    k19_pn  <= 28'(k18_n) * 28'(ftcd_pkg::YEAR_RECIP);
  end

  // Correct the year of the era
  assign y_est = k19_pn[27:ftcd_pkg::DOE_SH];
  assign y_rem = k19_n - 18'(y_est) * ftcd_pkg::DAYS_PER_YEAR;

  always_ff @(posedge clk) begin
    k20_era <= k19_era;
    k20_doe <= k19_doe;
    k20_yoe <= 9'(y_est + 10'(y_rem >= ftcd_pkg::DAYS_PER_YEAR));
  end

  // Find the day within the March-based year and the full year count
  assign cent = 2'(k20_yoe >= 9'd100) + 2'(k20_yoe >= 9'd200) + 2'(k20_yoe >= 9'd300);
  assign yday_start = 18'(k20_yoe) * ftcd_pkg::DAYS_PER_YEAR + 18'(k20_yoe[8:2])
                      - 18'(cent);

  always_ff @(posedge clk) begin
    k21_doy <= 9'(k20_doe - yday_start);
    k21_yy  <= 16'(k20_yoe) + 16'(k20_era) * ftcd_pkg::YEARS_PER_ERA;
  end

  // Estimate the month counted from March
  assign t5_comb = 11'(k21_doy) * 11'd5 + 11'd2;

  always_ff @(posedge clk) begin
    k22_doy <= k21_doy;
    k22_yy  <= k21_yy;
    k22_t5  <= t5_comb;
    k22_pm  <= 15'(t5_comb) * 15'(ftcd_pkg::MP_RECIP);
  end

  // Correct the month estimate
  assign mp_est = k22_pm[14:ftcd_pkg::MP_SH];
  assign mp_rem = k22_t5 - 11'(mp_est) * ftcd_pkg::DAYS_PER_5MONTH;

  always_ff @(posedge clk) begin
    k23_doy <= k22_doy;
    k23_yy  <= k22_yy;
    k23_mp  <= mp_est + 4'(mp_rem >= ftcd_pkg::DAYS_PER_5MONTH);
  end

  // Map to January-based month, day of month and civil year
  always_ff @(posedge clk) begin
    k24_day  <= 5'(k23_doy - ftcd_pkg::month_start(k23_mp) + 9'd1);
    if (k23_mp < 4'd10) begin
      k24_month <= k23_mp + 4'd3;
      k24_year  <= k23_yy;
    end else begin
      k24_month <= k23_mp - 4'd9;
      k24_year  <= k23_yy + 16'd1;
    end
  end

  // Hold the date until the clock fields catch up
  always_ff @(posedge clk) begin
    k25_year  <= k24_year;
    k25_month <= k24_month;
    k25_day   <= k24_day;
    k26_year  <= k25_year;
    k26_month <= k25_month;
    k26_day   <= k25_day;
  end

  // Estimate milliseconds and whole minutes of the day
  always_ff @(posedge clk) begin
    k23_rem2 <= rem2;
    k23_pms  <= 35'(rem2) * 35'(ftcd_pkg::MS_RECIP);
    k23_secs <= secs;
    k23_pmin <= 29'(secs) * 29'(ftcd_pkg::MIN_RECIP);
  end

  // Correct milliseconds and minutes; split off the second
  assign ms_est = k23_pms[34:ftcd_pkg::MS_SH];
  assign ms_rem = k23_rem2 - 24'(ms_est) * ftcd_pkg::TICKS_PER_MS;
  assign mt_est = k23_pmin[28:ftcd_pkg::MIN_SH];
  assign mt_rem = k23_secs - 17'(mt_est) * ftcd_pkg::SECS_PER_MIN;

  always_ff @(posedge clk) begin
    k24_ms <= 10'(ms_est + 11'(ms_rem >= ftcd_pkg::TICKS_PER_MS));
    if (mt_rem >= ftcd_pkg::SECS_PER_MIN) begin
      k24_mt  <= 11'(mt_est + 12'd1);
      k24_sec <= 6'(mt_rem - ftcd_pkg::SECS_PER_MIN);
    end else begin
      k24_mt  <= 11'(mt_est);
      k24_sec <= 6'(mt_rem);
    end
  end

  // Estimate the hour from the minute count
  always_ff @(posedge clk) begin
    k25_ms  <= k24_ms;
    k25_sec <= k24_sec;
    k25_mt  <= k24_mt;
    k25_ph  <= 23'(k24_mt) * 23'(ftcd_pkg::MIN_RECIP);
  end

  // Correct the hour and split off the minute
  assign h_est = k25_ph[22:ftcd_pkg::MIN_SH];
  assign h_rem = k25_mt - 11'(h_est) * ftcd_pkg::MIN_PER_HOUR;

  always_ff @(posedge clk) begin
    k26_ms  <= k25_ms;
    k26_sec <= k25_sec;
    if (h_rem >= ftcd_pkg::MIN_PER_HOUR) begin
      k26_hour <= 5'(h_est + 6'd1);
      k26_min  <= 6'(h_rem - ftcd_pkg::MIN_PER_HOUR);
    end else begin
      k26_hour <= 5'(h_est);
      k26_min  <= 6'(h_rem);
    end
  end

  // Drive the result word
  assign done         = vld[ftcd_pkg::LATENCY];
  assign year         = k26_year;
  assign month        = k26_month;
  assign day_of_month = k26_day;
  assign hour         = k26_hour;
  assign minute       = k26_min;
  assign second       = k26_sec;
  assign millisecond  = k26_ms;
  assign weekday      = wd_dly[ftcd_pkg::LATENCY];

endmodule

@@ rtl/ftcd_checker.sv @@
// ----------------------------------------------------------------------------
// ftcd_checker: port-level checks for the tick-count to calendar converter
// Watches the start/busy and done ports for timing and result ranges.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ftcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [15:0] year,
  input logic [3:0]  month,
  input logic [4:0]  day_of_month,
  input logic [4:0]  hour,
  input logic [5:0]  minute,
  input logic [5:0]  second,
  input logic [9:0]  millisecond,
  input logic [2:0]  weekday
);

  // No result word in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // Every taken word gives its result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
      (start && !busy) |-> ##(ftcd_pkg::LATENCY) done)
    else $error("result missing after fixed latency");

  // No result without a word taken at the fixed latency before
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
      done |-> $past(start && !busy, ftcd_pkg::LATENCY))
    else $error("result with no matching input word");

  // Fields stay within their calendar and clock ranges
  a_ranges: assert property (@(posedge clk) disable iff (rst)
      done |-> (year >= 16'd1601 && year <= 16'd60056 && month >= 4'd1 &&
                month <= 4'd12 && day_of_month >= 5'd1 && hour <= 5'd23 &&
                minute <= 6'd59 && second <= 6'd59 && millisecond <= 10'd999 &&
                weekday <= 3'd6))
    else $error("result field out of range");

  // Short months never show a day past their end
  a_month_length: assert property (@(posedge clk) disable iff (rst)
      done |-> ((month != 4'd2 || day_of_month <= 5'd29) &&
                ((month != 4'd4 && month != 4'd6 && month != 4'd9 &&
                  month != 4'd11) || day_of_month <= 5'd30)))
    else $error("day past end of month");

endmodule

bind filetime_to_civil_date ftcd_checker u_ftcd_checker (.*);
